// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/fsps_pkg.sv =====
`default_nettype none
package fsps_pkg;

  // pixel and phase widths
  localparam int PIXEL_BITS   = 8;
  localparam int PHASE_BITS   = 16;

  // cordic geometry
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int FRAC_BITS    = 32;
  localparam int ANGLE_W      = 32;
  // numerator and denominator span +-2*(2^PIXEL_BITS-1)
  localparam int NUM_W        = PIXEL_BITS + 2;
  // cordic gain times sqrt(2) stays below 4, plus sign and guard bit
  localparam int XY_W         = PIXEL_BITS + FRAC_BITS + 5;

  // pipeline depth: front register, cells, rounding register
  localparam int LATENCY      = CORDIC_STEPS + 2;

  localparam logic [ANGLE_W-1:0]    HALF_TURN_Z = ANGLE_W'(1) << (ANGLE_W - 1);
  localparam logic [ANGLE_W-1:0]    ROUND_ADD   = ANGLE_W'(1) << (ANGLE_W - 1 - PHASE_BITS);
  localparam logic [PHASE_BITS-1:0] HALF_TURN   = PHASE_BITS'(1) << (PHASE_BITS - 1);

  // control travelling alongside the data
  typedef struct packed {
    logic valid;
    logic nomod;
  } ctl_t;

  // cordic vector and angle accumulator
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ANGLE_W-1:0]     z;
  } cordic_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [ANGLE_W-1:0] arc_value(input logic [STEP_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fsps_front.sv =====
`default_nettype none
module fsps_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           xfer,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] i1,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] i2,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] i3,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] i4,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] i5,
  output fsps_pkg::ctl_t                      ctl_o,
  output fsps_pkg::cordic_t                   dat_o
);

  localparam int NW = fsps_pkg::NUM_W;
  localparam int XW = fsps_pkg::XY_W;
  localparam int FB = fsps_pkg::FRAC_BITS;

  logic signed [NW-1:0] num;
  logic signed [NW-1:0] den;
  logic signed [NW-1:0] num_rot;
  logic signed [NW-1:0] den_rot;
  fsps_pkg::ctl_t       ctl_r, ctl_nxt;
  fsps_pkg::cordic_t    dat_r, dat_nxt;

  // numerator 2*(i2-i4), denominator 2*i3-i1-i5
  always_comb begin
    num = (NW'(i2) - NW'(i4)) <<< 1;
    den = (NW'(i3) <<< 1) - NW'(i1) - NW'(i5);
  end

  // prerotate into the right half plane
  always_comb begin
    num_rot = den[NW-1] ? -num : num;
    den_rot = den[NW-1] ? -den : den;
    dat_nxt.x = XW'(den_rot) <<< FB;
    dat_nxt.y = XW'(num_rot) <<< FB;
    dat_nxt.z = den[NW-1] ? fsps_pkg::HALF_TURN_Z : '0;
    ctl_nxt.valid = xfer;
    ctl_nxt.nomod = (num == '0) && (den == '0);
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  assign ctl_o = ctl_r;
  assign dat_o = dat_r;

endmodule
`default_nettype wire

// ===== rtl/fsps_cell.sv =====
`default_nettype none
module fsps_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [fsps_pkg::STEP_W-1:0]       step_i,
  input  wire logic [fsps_pkg::ANGLE_W-1:0]      arc_i,
  input  wire fsps_pkg::ctl_t                    ctl_i,
  input  wire fsps_pkg::cordic_t                 dat_i,
  output fsps_pkg::ctl_t                         ctl_o,
  output fsps_pkg::cordic_t                      dat_o
);

  logic signed [fsps_pkg::XY_W-1:0] dx;
  logic signed [fsps_pkg::XY_W-1:0] dy;
  fsps_pkg::ctl_t                   ctl_r;
  fsps_pkg::cordic_t                dat_r, dat_nxt;

  // one micro-rotation, direction from the sign of y
  always_comb begin
    dx = dat_i.y >>> step_i;
    dy = dat_i.x >>> step_i;
    if (!dat_i.y[fsps_pkg::XY_W-1]) begin
      dat_nxt.x = dat_i.x + dx;
      dat_nxt.y = dat_i.y - dy;
      dat_nxt.z = dat_i.z + arc_i;
    end else begin
      dat_nxt.x = dat_i.x - dx;
      dat_nxt.y = dat_i.y + dy;
      dat_nxt.z = dat_i.z - arc_i;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
  end

  assign ctl_o = ctl_r;
  assign dat_o = dat_r;

endmodule
`default_nettype wire

// ===== rtl/fsps_round.sv =====
`default_nettype none
module fsps_round (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fsps_pkg::ctl_t                   ctl_i,
  input  wire logic [fsps_pkg::ANGLE_W-1:0]     z_i,
  output logic                                  valid_o,
  output logic [fsps_pkg::PHASE_BITS-1:0]       phase_o,
  output logic                                  nomod_o
);

  localparam int AW = fsps_pkg::ANGLE_W;
  localparam int PB = fsps_pkg::PHASE_BITS;

  logic [AW-1:0] turn;
  logic          valid_r;
  logic [PB-1:0] phase_r, phase_nxt;
  logic          nomod_r;

  // shift by half a turn, round half up, full turn wraps to zero; no modulation gives half a turn
  always_comb begin
    turn = z_i + fsps_pkg::HALF_TURN_Z + fsps_pkg::ROUND_ADD;
    phase_nxt = ctl_i.nomod ? fsps_pkg::HALF_TURN : turn[AW-1 -: PB];
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    nomod_r <= ctl_i.nomod;
  end

  assign valid_o = valid_r;
  assign phase_o = phase_r;
  assign nomod_o = nomod_r;

endmodule
`default_nettype wire

// ===== rtl/five_step_phase_shift.sv =====
// channel   direction  transfer condition        payload
// input     in         start high, busy low      in_frame_one .. in_frame_five
// result    out        out_valid high            out_wrapped_phase, out_no_modulation
//
// one pixel is taken every cycle; its result transfer comes once the pixel has passed through the whole depth
// the depth is the front register, 30 cordic cells and the rounding register
// busy is high only while rst_n is low; synchronous reset flushes the pipeline
// results are strobed for one cycle and cannot be held off by the receiver
`default_nettype none
`include "assert_macros.svh"
module five_step_phase_shift (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0]  in_frame_one,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0]  in_frame_two,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0]  in_frame_three,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0]  in_frame_four,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0]  in_frame_five,
  output logic                                  out_valid,
  output logic [fsps_pkg::PHASE_BITS-1:0]       out_wrapped_phase,
  output logic                                  out_no_modulation
);

  localparam int NS = fsps_pkg::CORDIC_STEPS;

  logic              in_xfer;
  fsps_pkg::ctl_t    ctl_chain [NS+1];
  fsps_pkg::cordic_t dat_chain [NS+1];

  // accept whenever out of reset
  assign busy    = ~rst_n;
  assign in_xfer = start & ~busy;

  // differences and prerotation
  fsps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .xfer  (in_xfer),
    .i1    (in_frame_one),
    .i2    (in_frame_two),
    .i3    (in_frame_three),
    .i4    (in_frame_four),
    .i5    (in_frame_five),
    .ctl_o (ctl_chain[0]),
    .dat_o (dat_chain[0])
  );

  // row of cordic cells
  for (genvar g = 0; g < NS; g++) begin : g_cell
    fsps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step_i (fsps_pkg::STEP_W'(g)),
      .arc_i  (fsps_pkg::arc_value(fsps_pkg::STEP_W'(g))),
      .ctl_i  (ctl_chain[g]),
      .dat_i  (dat_chain[g]),
      .ctl_o  (ctl_chain[g+1]),
      .dat_o  (dat_chain[g+1])
    );
  end

  // offset, rounding and result register
  fsps_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_chain[NS]),
    .z_i     (dat_chain[NS].z),
    .valid_o (out_valid),
    .phase_o (out_wrapped_phase),
    .nomod_o (out_no_modulation)
  );

  // checks
  `ASSERT_IMPLY(a_latency, clk, rst_n, out_valid, $past(in_xfer, fsps_pkg::LATENCY))
  `ASSERT_IMPLY(a_nomod_half, clk, rst_n, out_valid && out_no_modulation, out_wrapped_phase == fsps_pkg::HALF_TURN)
  `ASSERT_IMPLY(a_nomod_zero, clk, rst_n, ctl_chain[0].valid && ctl_chain[0].nomod, (dat_chain[0].x == '0) && (dat_chain[0].y == '0))
  `ASSERT_NEXT(a_right_half, clk, rst_n, in_xfer, !dat_chain[0].x[fsps_pkg::XY_W-1])

endmodule
`default_nettype wire

// ===== test/phase_checker.sv =====
module phase_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] frame_one,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] frame_two,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] frame_three,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] frame_four,
  input  wire logic [fsps_pkg::PIXEL_BITS-1:0] frame_five,
  input  wire logic                            out_valid,
  input  wire logic [fsps_pkg::PHASE_BITS-1:0] wrapped_phase,
  input  wire logic                            no_modulation,
  output int                                   mismatches,
  output int                                   awaiting,
  output int                                   compared,
  output int                                   flat_pixels
);

  localparam int PB         = fsps_pkg::PIXEL_BITS;
  localparam int QB         = fsps_pkg::PHASE_BITS;
  localparam int ROTATIONS  = 30;
  localparam int REPORT_MAX = 10;

  // arctangent of 2^-i as a fraction of a turn, 2^-32 turn per lsb
  localparam logic [31:0] ARC_TURN [0:ROTATIONS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // one pixel with the phase it should produce
  typedef struct packed {
    logic [PB-1:0] i1;
    logic [PB-1:0] i2;
    logic [PB-1:0] i3;
    logic [PB-1:0] i4;
    logic [PB-1:0] i5;
    logic [QB-1:0] phase;
    logic          flat;
  } pixel_phase_t;

  pixel_phase_t phase_queue[$];
  int fail_total = 0;
  int compare_total = 0;
  int flat_total = 0;

  // five-step demodulation: vectoring cordic on (den, num), then rotate by a half turn
  function automatic pixel_phase_t demodulate(input logic [PB-1:0] i1, i2, i3, i4, i5);
    pixel_phase_t r;
    longint num;
    longint den;
    longint x;
    longint y;
    longint dx;
    longint dy;
    logic [31:0] z;
    logic [31:0] t;
    r.i1 = i1;
    r.i2 = i2;
    r.i3 = i3;
    r.i4 = i4;
    r.i5 = i5;
    num = 2 * (longint'(i2) - longint'(i4));
    den = 2 * longint'(i3) - longint'(i1) - longint'(i5);
    if (num == 0 && den == 0) begin
      r.phase = QB'(1) << (QB - 1);
      r.flat  = 1'b1;
      return r;
    end
    x = den * (longint'(1) <<< 32);
    y = num * (longint'(1) <<< 32);
    z = '0;
    // left half plane: fold over by a half turn
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARC_TURN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARC_TURN[i];
      end
    end
    // shift into 0..2pi and round half up, a full turn wraps to zero
    t = z + 32'h8000_0000 + (32'd1 << (31 - QB));
    r.phase = t[31 -: QB];
    r.flat  = 1'b0;
    return r;
  endfunction

  // watch both channels, queue predictions and compare in order
  always @(posedge clk) begin : watch
    pixel_phase_t want;
    if (rst_n) begin
      if (start && !busy) begin
        phase_queue = {phase_queue, demodulate(frame_one, frame_two, frame_three,
                                               frame_four, frame_five)};
      end
      if (out_valid !== 1'b0) begin
        if (phase_queue.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX)
            $display("unexpected result transfer: phase %0h flag %b valid %b",
                     wrapped_phase, no_modulation, out_valid);
        end else begin
          want = phase_queue.pop_front();
          compare_total++;
          if (want.flat)
            flat_total++;
          if (want.phase !== wrapped_phase || want.flat !== no_modulation) begin
            fail_total++;
            if (fail_total <= REPORT_MAX)
              $display("pixel %0d %0d %0d %0d %0d: phase exp %0h got %0h, flag exp %b got %b",
                       want.i1, want.i2, want.i3, want.i4, want.i5,
                       want.phase, wrapped_phase, want.flat, no_modulation);
          end
        end
      end
    end
    mismatches  <= fail_total;
    awaiting    <= phase_queue.size();
    compared    <= compare_total;
    flat_pixels <= flat_total;
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int PB            = fsps_pkg::PIXEL_BITS;
  localparam int QB            = fsps_pkg::PHASE_BITS;
  localparam int PIX_MAX       = (1 << PB) - 1;
  localparam int RANDOM_PIXELS = 950;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 1000;

  logic          clk;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [PB-1:0] frame_one = '0;
  logic [PB-1:0] frame_two = '0;
  logic [PB-1:0] frame_three = '0;
  logic [PB-1:0] frame_four = '0;
  logic [PB-1:0] frame_five = '0;
  wire           busy;
  wire           out_valid;
  wire  [QB-1:0] out_wrapped_phase;
  wire           out_no_modulation;

  int mismatches;
  int awaiting;
  int compared;
  int flat_pixels;
  int sent = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  five_step_phase_shift dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_frame_one      (frame_one),
    .in_frame_two      (frame_two),
    .in_frame_three    (frame_three),
    .in_frame_four     (frame_four),
    .in_frame_five     (frame_five),
    .out_valid         (out_valid),
    .out_wrapped_phase (out_wrapped_phase),
    .out_no_modulation (out_no_modulation)
  );

  phase_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .frame_one     (frame_one),
    .frame_two     (frame_two),
    .frame_three   (frame_three),
    .frame_four    (frame_four),
    .frame_five    (frame_five),
    .out_valid     (out_valid),
    .wrapped_phase (out_wrapped_phase),
    .no_modulation (out_no_modulation),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .compared      (compared),
    .flat_pixels   (flat_pixels)
  );

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one pixel transfer, then a random gap; some stretches run back to back
  task automatic send_pixel(input logic [PB-1:0] a, b, c, d, e);
    int gap;
    gap = ((sent / 50) % 4 == 1) ? 0 : $urandom_range(0, MAX_GAP);
    start       <= 1'b1;
    frame_one   <= a;
    frame_two   <= b;
    frame_three <= c;
    frame_four  <= d;
    frame_five  <= e;
    do @(posedge clk); while (busy);
    sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // outer frames around a middle one so that the denominator is zero
  task automatic flat_denominator(output logic [PB-1:0] lo, mid, hi);
    int c;
    int lim;
    int d;
    c   = $urandom_range(0, PIX_MAX);
    lim = (c < PIX_MAX - c) ? c : PIX_MAX - c;
    d   = $urandom_range(0, lim);
    mid = PB'(c);
    if ($urandom_range(0, 1)) begin
      lo = PB'(c - d);
      hi = PB'(c + d);
    end else begin
      lo = PB'(c + d);
      hi = PB'(c - d);
    end
  endtask

  // intensity close to a base level, clamped to the pixel range
  function automatic logic [PB-1:0] near_level(input int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0)
      v = 0;
    if (v > PIX_MAX)
      v = PIX_MAX;
    return PB'(v);
  endfunction

  initial begin : stimulus
    logic [PB-1:0] f1, f2, f3, f4, f5;
    int mode;
    int base;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // flat pixels: no modulation
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(255, 255, 255, 255, 255);
    send_pixel(170, 85, 170, 85, 170);
    // negative real axis wraps to zero, large and tiny denominator
    send_pixel(255, 7, 0, 7, 255);
    send_pixel(1, 0, 0, 0, 0);
    // positive real axis
    send_pixel(0, 9, 255, 9, 0);
    send_pixel(1, 0, 1, 0, 0);
    // imaginary axis, both signs, extreme and small, then a flat pixel
    send_pixel(100, 255, 100, 0, 100);
    send_pixel(100, 0, 100, 255, 100);
    send_pixel(0, 1, 0, 0, 0);
    send_pixel(0, 0, 0, 1, 0);
    send_pixel(85, 170, 85, 170, 85);
    // four diagonals at full scale, then one at small scale
    send_pixel(0, 255, 255, 0, 0);
    send_pixel(255, 255, 0, 0, 255);
    send_pixel(255, 0, 0, 255, 255);
    send_pixel(0, 0, 255, 255, 0);
    send_pixel(0, 10, 10, 0, 0);
    // just either side of the wrap point, then a small signal
    send_pixel(255, 1, 0, 0, 255);
    send_pixel(255, 0, 0, 1, 255);
    send_pixel(128, 127, 128, 128, 127);

    // random pixels, weighted toward axes, flat pixels, small signals and full-scale extremes
    repeat (RANDOM_PIXELS) begin
      mode = $urandom_range(0, 9);
      f1 = PB'($urandom_range(0, PIX_MAX));
      f2 = PB'($urandom_range(0, PIX_MAX));
      f3 = PB'($urandom_range(0, PIX_MAX));
      f4 = PB'($urandom_range(0, PIX_MAX));
      f5 = PB'($urandom_range(0, PIX_MAX));
      case (mode)
        0: begin
          f4 = f2;
          flat_denominator(f1, f3, f5);
        end
        1: begin
          f4 = f2;
        end
        2: begin
          flat_denominator(f1, f3, f5);
        end
        3: begin
          base = $urandom_range(0, PIX_MAX);
          f1 = near_level(base);
          f2 = near_level(base);
          f3 = near_level(base);
          f4 = near_level(base);
          f5 = near_level(base);
        end
        4: begin
          f1 = $urandom_range(0, 1) ? PB'(PIX_MAX) : '0;
          f2 = $urandom_range(0, 1) ? PB'(PIX_MAX) : '0;
          f3 = $urandom_range(0, 1) ? PB'(PIX_MAX) : '0;
          f4 = $urandom_range(0, 1) ? PB'(PIX_MAX) : '0;
          f5 = $urandom_range(0, 1) ? PB'(PIX_MAX) : '0;
        end
        default: begin
        end
      endcase
      send_pixel(f1, f2, f3, f4, f5);
    end
    start <= 1'b0;

    // drain the pipeline
    while (awaiting != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d pixels, compared %0d phases, %0d of them without modulation",
             sent, compared, flat_pixels);
    $display("directed axes, diagonals and wrap points, then weighted random pixels");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
